FILE: rtl/core/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// Shared widths, command codes and controller/datapath interface structs for
// the software timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;

    // field widths
    localparam int OP_W        = 3;
    localparam int SLOT_PORT_W = 4;
    localparam int MS_W        = 24;
    localparam int CNT_W       = 21;
    localparam int PROD_W      = 2 * MS_W;

    // a result names at most this many slots
    localparam int MAX_SLOTS      = 16;
    localparam int NUM_TIMERS_DEF = 16;

    // one tick is this many milliseconds
    localparam int PERIOD_MS = 10;

    // ms / 10 as (ms * ceil(2^27 / 10)) >> 27, exact for all 24-bit inputs
    localparam logic [MS_W-1:0] DIV10_RECIP = 24'd13421773;
    localparam int              DIV10_SHIFT = 27;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
    localparam logic [OP_W-1:0] OP_START   = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP    = 3'd4;

    // result codes
    localparam logic EV_CMD    = 1'b0;
    localparam logic EV_EXPIRY = 1'b1;
    localparam logic ST_OK     = 1'b0;
    localparam logic ST_FAIL   = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic walk_init;
        logic walk_step;
        logic flush;
    } stb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic op_tick;
        logic out_free;
        logic walk_stall;
        logic walk_last;
        logic pend_valid;
    } stb_stat_t;

endpackage

FILE: rtl/core/stb_ctrl.sv
// ----------------------------------------------------------------------------
// stb_ctrl
// Sequencer for the timer bank: accepts one transaction, then either applies
// the command or walks the slots for a tick, one slot per cycle unless stalled.
// ----------------------------------------------------------------------------
module stb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  stb_pkg::stb_stat_t stat,
    output stb_pkg::stb_cmd_t  cmd
);
    import stb_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_EXEC   = 5'b00100,
        ST_WALK   = 5'b01000,
        ST_FLUSH  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (stat.op_tick) begin
                    cmd.walk_init = 1'b1;
                    state_next    = ST_WALK;
                end else begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_WALK: begin
                // hold the slot while an earlier expiry cannot leave
                if (!stat.walk_stall) begin
                    cmd.walk_step = 1'b1;
                    if (stat.walk_last) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!stat.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/stb_datapath.sv
// ----------------------------------------------------------------------------
// stb_datapath
// Slot state, reload/count memories, divide-by-ten, expiry look-behind and
// the output register of the timer bank.
// ----------------------------------------------------------------------------
module stb_datapath #(
    parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    input  logic [stb_pkg::OP_W-1:0]        s_operation,
    input  logic [stb_pkg::SLOT_PORT_W-1:0] s_slot_index,
    input  logic [stb_pkg::MS_W-1:0]        s_timeout_ms,
    input  logic                            s_periodic,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_event_kind,
    output logic                            m_status,
    output logic [stb_pkg::SLOT_PORT_W-1:0] m_result_slot,
    output logic                            m_last,
    input  stb_pkg::stb_cmd_t               cmd,
    output stb_pkg::stb_stat_t              stat
);
    import stb_pkg::*;

    localparam int SLOTS     = (NUM_TIMERS < MAX_SLOTS) ? NUM_TIMERS : MAX_SLOTS;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IDX_CMP_W = SLOT_PORT_W + 1;

    // latched transaction
    logic [OP_W-1:0]        op_reg;
    logic [SLOT_PORT_W-1:0] idx_reg;
    logic [MS_W-1:0]        ms_reg;
    logic                   per_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic                   ready_reg;

    // per-slot flags
    logic [SLOTS-1:0] alloc_reg, alloc_next;
    logic [SLOTS-1:0] run_reg, run_next;
    logic [SLOTS-1:0] perb_reg, perb_next;

    // reload and count storage
    logic [CNT_W-1:0] reload_mem [SLOTS];
    logic [CNT_W-1:0] count_mem [SLOTS];
    logic [CNT_W-1:0] reload_rd_reg;
    logic [CNT_W-1:0] count_rd_reg;

    // tick walk
    logic [SLOT_W-1:0] ptr_reg, ptr_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;

    // output register
    logic                   m_valid_reg, m_valid_next;
    logic                   kind_reg;
    logic                   status_reg;
    logic [SLOT_PORT_W-1:0] slot_reg;
    logic                   last_reg;

    logic              idx_ok;
    logic [SLOT_W-1:0] idx_s;
    logic [CNT_W-1:0]  quot;
    logic [MS_W:0]     quot10;
    logic              start_ok;
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
    logic              act;
    logic [CNT_W-1:0]  cnt_inc;
    logic              expire;
    logic              out_free;
    logic              push;

    logic                   cmd_fail;
    logic [SLOT_PORT_W-1:0] cmd_slot;
    logic                   cnt_we;
    logic [SLOT_W-1:0]      cnt_waddr;
    logic [CNT_W-1:0]       cnt_wdata;
    logic                   rl_we;
    logic [CNT_W-1:0]       rl_wdata;
    logic                   rd_en;
    logic [SLOT_W-1:0]      rd_addr;

    assign idx_ok   = {1'b0, idx_reg} < IDX_CMP_W'(SLOTS);
    assign idx_s    = idx_reg[SLOT_W-1:0];
    assign quot     = prod_reg[DIV10_SHIFT +: CNT_W];
    assign quot10   = (MS_W+1)'(quot) * (MS_W+1)'(PERIOD_MS);
    assign start_ok = idx_ok && ready_reg && (ms_reg != '0) && (quot10 == {1'b0, ms_reg})
                      && alloc_reg[idx_s];

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!alloc_reg[i]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    assign act      = alloc_reg[ptr_reg] && run_reg[ptr_reg];
    assign cnt_inc  = count_rd_reg + CNT_W'(1);
    assign expire   = act && (cnt_inc >= reload_rd_reg);
    assign out_free = !m_valid_reg || m_ready;

    // an expiry is held back until the next one or the end of the walk
    // shows whether it is the last
    assign push = cmd.exec || cmd.flush || (cmd.walk_step && expire && pend_valid_reg);

    assign stat.op_tick    = (op_reg == OP_TICK);
    assign stat.out_free   = out_free;
    assign stat.walk_stall = expire && pend_valid_reg && !out_free;
    assign stat.walk_last  = (ptr_reg == SLOT_W'(SLOTS - 1));
    assign stat.pend_valid = pend_valid_reg;

    always_comb begin
        alloc_next = alloc_reg;
        run_next   = run_reg;
        perb_next  = perb_reg;
        cmd_fail   = ST_FAIL;
        cmd_slot   = idx_reg;
        cnt_we     = 1'b0;
        cnt_waddr  = ptr_reg;
        cnt_wdata  = '0;
        rl_we      = 1'b0;
        rl_wdata   = '0;

        if (cmd.walk_step) begin
            if (act) begin
                cnt_we    = 1'b1;
                cnt_wdata = expire ? '0 : cnt_inc;
            end
            if (expire && !perb_reg[ptr_reg]) begin
                run_next[ptr_reg] = 1'b0;
            end
        end

        case (op_reg)
            OP_ALLOC: begin
                if (ready_reg && free_found) begin
                    cmd_fail = ST_OK;
                    cmd_slot = SLOT_PORT_W'(free_slot);
                    if (cmd.exec) begin
                        alloc_next[free_slot] = 1'b1;
                        run_next[free_slot]   = 1'b0;
                        perb_next[free_slot]  = 1'b0;
                    end
                end else begin
                    cmd_slot = '0;
                end
            end
            OP_RELEASE: begin
                if (idx_ok) begin
                    cmd_fail = ST_OK;
                    if (cmd.exec) begin
                        alloc_next[idx_s] = 1'b0;
                        run_next[idx_s]   = 1'b0;
                        rl_we             = 1'b1;
                    end
                end
            end
            OP_START: begin
                if (start_ok) begin
                    cmd_fail = ST_OK;
                    if (cmd.exec) begin
                        run_next[idx_s]  = 1'b1;
                        perb_next[idx_s] = per_reg;
                        rl_we            = 1'b1;
                        rl_wdata         = quot;
                        cnt_we           = 1'b1;
                        cnt_waddr        = idx_s;
                    end
                end
            end
            OP_STOP: begin
                if (idx_ok && alloc_reg[idx_s]) begin
                    cmd_fail = ST_OK;
                    if (cmd.exec) begin
                        run_next[idx_s] = 1'b0;
                    end
                end
            end
            default: begin
                cmd_fail = ST_FAIL;
            end
        endcase
    end

    always_comb begin
        ptr_next        = ptr_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        if (cmd.walk_init) begin
            ptr_next        = '0;
            pend_valid_next = 1'b0;
        end else if (cmd.walk_step) begin
            ptr_next = ptr_reg + SLOT_W'(1);
            if (expire) begin
                pend_valid_next = 1'b1;
                pend_slot_next  = ptr_reg;
            end
        end else if (cmd.flush) begin
            pend_valid_next = 1'b0;
        end
    end

    assign rd_en   = cmd.walk_init || cmd.walk_step;
    assign rd_addr = cmd.walk_init ? '0 : (ptr_reg + SLOT_W'(1));

    always_comb begin
        m_valid_next = m_valid_reg;
        if (push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg      <= 1'b1;
            alloc_reg      <= '0;
            run_reg        <= '0;
            perb_reg       <= '0;
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                ready_reg <= cfg_wr_data;
            end
            alloc_reg      <= alloc_next;
            run_reg        <= run_next;
            perb_reg       <= perb_next;
            ptr_reg        <= ptr_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        pend_slot_reg <= pend_slot_next;
        if (cmd.load) begin
            op_reg   <= s_operation;
            idx_reg  <= s_slot_index;
            ms_reg   <= s_timeout_ms;
            per_reg  <= s_periodic;
            prod_reg <= PROD_W'(s_timeout_ms) * PROD_W'(DIV10_RECIP);
        end
        if (push) begin
            kind_reg   <= cmd.exec ? EV_CMD : EV_EXPIRY;
            status_reg <= cmd.exec ? cmd_fail : ST_OK;
            slot_reg   <= cmd.exec ? cmd_slot : SLOT_PORT_W'(pend_slot_reg);
            last_reg   <= cmd.exec || cmd.flush;
        end
    end

    // slot memories, registered read
    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        if (rl_we) begin
            reload_mem[idx_s] <= rl_wdata;
        end
        if (rd_en) begin
            count_rd_reg  <= count_mem[rd_addr];
            reload_rd_reg <= reload_mem[rd_addr];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_event_kind  = kind_reg;
    assign m_status      = status_reg;
    assign m_result_slot = slot_reg;
    assign m_last        = last_reg;

endmodule

FILE: rtl/core/software_timer_bank.sv
// Command: the transaction is latched, decoded and executed; the result is
// registered once the output register is free. Tick: the slots are walked in
// order via the single read port of the count/reload memories; output stalls hold it.
// One transaction is in work at a time; the next is accepted while the last
// result still waits in the output register.
// Reset (aresetn low, synchronous): all slots free and stopped, ready_reg = 1.
// ----------------------------------------------------------------------------
// software_timer_bank
// Bank of timer slots with allocate, release, start, stop and tick commands,
// reporting command completions and per-slot expiries in slot order.
// ----------------------------------------------------------------------------
module software_timer_bank #(
    parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [stb_pkg::OP_W-1:0]        s_operation,
    input  logic [stb_pkg::SLOT_PORT_W-1:0] s_slot_index,
    input  logic [stb_pkg::MS_W-1:0]        s_timeout_ms,
    input  logic                            s_periodic,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_event_kind,
    output logic                            m_status,
    output logic [stb_pkg::SLOT_PORT_W-1:0] m_result_slot,
    output logic                            m_last
);
    import stb_pkg::*;

    stb_cmd_t  cmd;
    stb_stat_t stat;

    stb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    stb_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_operation   (s_operation),
        .s_slot_index  (s_slot_index),
        .s_timeout_ms  (s_timeout_ms),
        .s_periodic    (s_periodic),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_status      (m_status),
        .m_result_slot (m_result_slot),
        .m_last        (m_last),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule
